/* hdl/cfp_pkg.sv */
// Shared types, constants and the CRC-16/KERMIT byte update for the frame parser.
// No dependencies; used by every module of the parser.
package cfp_pkg;

  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [15:0] CrcInit = 16'h0000;
  localparam logic [7:0]  StartByteRst = 8'hAA;

  typedef enum logic [4:0] {
    PH_SOF  = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_PAY  = 5'b00100,
    PH_CRCL = 5'b01000,
    PH_CRCH = 5'b10000
  } phase_e;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [5:0] position;
    logic [6:0] pay_len;
    logic       crc_ok;
  } result_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/cfp_parser.sv */
// Frame state machine with running CRC; updates state on each input transfer.
// Depends on cfp_pkg for the phase type, result struct and CRC update.
module cfp_parser #(
  parameter int MAX_LEN = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       start_byte_i,
  output logic             res_valid_o,
  output cfp_pkg::result_t res_o
);

  localparam int LenW = $clog2(MAX_LEN + 1);
  localparam logic [8:0] MaxLenC = 9'(MAX_LEN);

  cfp_pkg::phase_e phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crcl_q, crcl_d;
  logic [LenW-1:0] cnt_inc;
  logic [LenW-1:0] rx_len;

  assign cnt_inc = cnt_q + LenW'(1);
  assign rx_len  = LenW'(rx_byte_i);

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    crcl_d      = crcl_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      cfp_pkg::PH_LEN: begin
        if ({1'b0, rx_byte_i} > MaxLenC) begin
          phase_d = cfp_pkg::PH_SOF;
        end else begin
          len_d   = rx_len;
          cnt_d   = '0;
          crc_d   = cfp_pkg::crc_update(crc_q, rx_byte_i);
          phase_d = (rx_byte_i == 8'h00) ? cfp_pkg::PH_CRCL : cfp_pkg::PH_PAY;
        end
      end
      cfp_pkg::PH_PAY: begin
        crc_d = cfp_pkg::crc_update(crc_q, rx_byte_i);
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = cfp_pkg::PH_CRCL;
        end
        res_valid_o     = 1'b1;
        res_o.kind      = cfp_pkg::KindPayload;
        res_o.data      = rx_byte_i;
        res_o.position  = 6'(cnt_q);
        res_o.pay_len   = 7'(len_q);
      end
      cfp_pkg::PH_CRCL: begin
        crcl_d  = rx_byte_i;
        phase_d = cfp_pkg::PH_CRCH;
      end
      cfp_pkg::PH_CRCH: begin
        phase_d         = cfp_pkg::PH_SOF;
        res_valid_o     = 1'b1;
        res_o.kind      = cfp_pkg::KindEnd;
        res_o.pay_len   = 7'(len_q);
        res_o.crc_ok    = ({rx_byte_i, crcl_q} == crc_q);
      end
      default: begin
        phase_d = cfp_pkg::PH_SOF;
        if (rx_byte_i == start_byte_i) begin
          crc_d   = cfp_pkg::crc_update(cfp_pkg::CrcInit, rx_byte_i);
          phase_d = cfp_pkg::PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfp_pkg::PH_SOF;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= cfp_pkg::CrcInit;
      crcl_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      crcl_q  <= crcl_d;
    end
  end

endmodule

/* hdl/cfp_out_reg.sv */
// Result register between the parser and the output channel.
// Depends on cfp_pkg for the result struct.
module cfp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  cfp_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output cfp_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  cfp_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/crc16_framed_byte_parser.sv */
// Top level of the CRC-16/KERMIT framed byte parser.
// Depends on cfp_pkg, cfp_parser and cfp_out_reg.
//
// Usage:
//   Input channel: rx_byte_i with in_valid_i / in_ready_o; one byte per transfer.
//   Output channel: kind_o, data_o, position_o, pay_len_o, crc_ok_o with
//   out_valid_o / out_ready_i. Each payload byte yields one result (kind 0);
//   the CRC high byte yields an end report (kind 1) with crc_ok_o.
//   Start, length and CRC low bytes, bytes seen while hunting and oversized
//   length bytes yield no result.
//   Configuration: cfg_we_i writes cfg_wdata_i into the start byte register,
//   reset value 0xAA. Write only while idle.
//   Results are registered: each appears in the cycle after its byte transfer.
//   Throughput: one byte per cycle unless the output stalls; the CRC byte update
//   and state machine are combinational between the input transfer and the result register.
//   Stall: while a result waits and out_ready_i is low, in_ready_o is low;
//   the result register holds until it is taken.
//   Reset: the parser returns to hunting for the start byte, the CRC clears
//   and no result is pending.
module crc16_framed_byte_parser #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] data_o,
  output logic [5:0] position_o,
  output logic [6:0] pay_len_o,
  output logic       crc_ok_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0]       start_q;
  logic             accept;
  logic             res_valid;
  cfp_pkg::result_t res, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= cfp_pkg::StartByteRst;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o   = !out_valid_o || out_ready_i;
  assign accept       = in_valid_i && in_ready_o;

  cfp_parser #(
    .MAX_LEN(MAX_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .start_byte_i(start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_valid_i(res_valid),
    .res_i      (res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  assign kind_o      = res_out.kind;
  assign data_o      = res_out.data;
  assign position_o  = res_out.position;
  assign pay_len_o   = res_out.pay_len;
  assign crc_ok_o    = res_out.crc_ok;

  a_end_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> data_o == 8'h00 && position_o == 6'd0)
    else $error("end report carries payload fields");

  a_payload_no_crc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !crc_ok_o)
    else $error("payload result flags crc_ok");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i |=> out_valid_o && $stable(res_out))
    else $error("pending result overwritten");

endmodule

/* tb/crc16_framed_byte_parser_tb.sv */
// Self-checking testbench for crc16_framed_byte_parser: sends start/length/payload/CRC
// frames, noise and broken frames, predicts every result and checks each one in order.
// Depends on cfp_pkg and the parser RTL.
module crc16_framed_byte_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen        = 64;
  localparam int RxBurstTarget = 440;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 4;
  localparam int WatchdogLimit = 3000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [7:0] data;
  logic [5:0] position;
  logic [6:0] pay_len;
  logic       crc_ok;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  crc16_framed_byte_parser #(.MAX_LEN(MaxLen)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .kind_o     (kind),
    .data_o     (data),
    .position_o (position),
    .pay_len_o  (pay_len),
    .crc_ok_o   (crc_ok),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  // parser shadow state
  cfp_pkg::phase_e  exp_phase     = cfp_pkg::PH_SOF;
  logic [7:0]       exp_start     = cfp_pkg::StartByteRst;
  logic [6:0]       exp_len       = '0;
  logic [6:0]       exp_count     = '0;
  logic [15:0]      exp_crc       = cfp_pkg::CrcInit;
  logic [7:0]       exp_crc_low   = '0;
  cfp_pkg::result_t frame_results_q[$];

  logic [7:0]  tx_q[$];
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  bit          hold_off_req  = 1'b0;

  int errors        = 0;
  int bytes_sent    = 0;
  int payload_seen  = 0;
  int reports_seen  = 0;
  int crc_good_seen = 0;
  int len_drops     = 0;
  int start_writes  = 0;
  int no_progress   = 0;

  function automatic logic [15:0] kermit_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = {1'b0, r[15:1]} ^ cfp_pkg::CrcPoly;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(int pct);
    if (int'($urandom_range(99)) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    cfp_pkg::result_t r;
    r = '0;
    case (exp_phase)
      cfp_pkg::PH_LEN: begin
        if (int'(b) > MaxLen) begin
          exp_phase = cfp_pkg::PH_SOF;
          len_drops++;
        end else begin
          exp_len   = b[6:0];
          exp_count = '0;
          exp_crc   = kermit_step(exp_crc, b);
          exp_phase = (b == 8'd0) ? cfp_pkg::PH_CRCL : cfp_pkg::PH_PAY;
        end
      end
      cfp_pkg::PH_PAY: begin
        r.kind      = cfp_pkg::KindPayload;
        r.data      = b;
        r.position  = exp_count[5:0];
        r.pay_len   = exp_len;
        r.crc_ok    = 1'b0;
        frame_results_q.push_back(r);
        exp_crc   = kermit_step(exp_crc, b);
        exp_count = exp_count + 7'd1;
        if (exp_count >= exp_len) exp_phase = cfp_pkg::PH_CRCL;
      end
      cfp_pkg::PH_CRCL: begin
        exp_crc_low = b;
        exp_phase   = cfp_pkg::PH_CRCH;
      end
      cfp_pkg::PH_CRCH: begin
        r.kind      = cfp_pkg::KindEnd;
        r.pay_len   = exp_len;
        r.crc_ok    = ({b, exp_crc_low} == exp_crc);
        frame_results_q.push_back(r);
        exp_phase = cfp_pkg::PH_SOF;
      end
      default: begin
        exp_phase = cfp_pkg::PH_SOF;
        if (b == exp_start) begin
          exp_crc   = kermit_step(cfp_pkg::CrcInit, b);
          exp_phase = cfp_pkg::PH_LEN;
        end
      end
    endcase
  endtask

  initial begin : byte_driver
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0 || tx_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap > 0) gap--;
      end else begin
        in_valid <= 1'b1;
        rx_byte  <= tx_q[0];
      end
      @(posedge clk);
      if (in_valid && in_ready) begin
        parse_rx_byte(rx_byte);
        void'(tx_q.pop_front());
        gap = pick_gap(src_idle_pct);
      end
    end
  end

  initial begin : result_sink
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        gap = pick_gap(sink_idle_pct);
      end
    end
  end

  task automatic check_result();
    cfp_pkg::result_t got;
    cfp_pkg::result_t want;
    got = {kind, data, position, pay_len, crc_ok};
    if (frame_results_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result kind=%0d data=%02h pos=%0d len=%0d ok=%0d",
               $time, got.kind, got.data, got.position, got.pay_len, got.crc_ok);
      return;
    end
    want = frame_results_q.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: mismatch expected kind=%0d data=%02h pos=%0d len=%0d ok=%0d",
               $time, want.kind, want.data, want.position, want.pay_len, want.crc_ok);
      $display("%0t:          actual   kind=%0d data=%02h pos=%0d len=%0d ok=%0d",
               $time, got.kind, got.data, got.position, got.pay_len, got.crc_ok);
    end
    if (want.kind == cfp_pkg::KindEnd) begin
      reports_seen++;
      if (want.crc_ok) crc_good_seen++;
    end else begin
      payload_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      no_progress = 0;
    end else begin
      no_progress++;
    end
    if (no_progress >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (tx_q.size() >= 4) @(posedge clk);
    tx_q.push_back(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] payload[$], input logic [15:0] crc_flip);
    logic [15:0] acc;
    logic [7:0]  n;
    n   = 8'(payload.size());
    acc = kermit_step(kermit_step(cfp_pkg::CrcInit, exp_start), n);
    send_byte(exp_start);
    send_byte(n);
    foreach (payload[i]) begin
      acc = kermit_step(acc, payload[i]);
      send_byte(payload[i]);
    end
    acc ^= crc_flip;
    send_byte(acc[7:0]);
    send_byte(acc[15:8]);
  endtask

  task automatic random_payload(output logic [7:0] payload[$], input int n);
    payload = {};
    repeat (n) payload.push_back(8'($urandom));
  endtask

  task automatic wait_for_drain();
    while (tx_q.size() != 0 || in_valid || frame_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    exp_start = v;
    start_writes++;
  endtask

  task automatic test_basic_frames();
    logic [7:0] p[$];
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    p = {8'h00, 8'hFF};
    send_frame(p, 16'h0000);
    p = {};
    send_frame(p, 16'h0000);
    p = {8'h5A};
    send_frame(p, 16'h8001);
  endtask

  task automatic test_oversized_length();
    logic [7:0] p[$];
    send_byte(exp_start);
    send_byte(8'(MaxLen + 1));
    send_byte(exp_start);
    send_byte(exp_start);
    p = {};
    send_frame(p, 16'h0000);
  endtask

  task automatic test_midframe_start_change();
    logic [15:0] acc;
    logic [7:0]  b;
    logic [7:0]  p[$];
    send_byte(exp_start);
    send_byte(8'd3);
    b = 8'($urandom);
    send_byte(b);
    acc = kermit_step(kermit_step(kermit_step(cfp_pkg::CrcInit, exp_start), 8'd3), b);
    write_start_byte(8'h3C);
    repeat (2) begin
      b = 8'($urandom);
      acc = kermit_step(acc, b);
      send_byte(b);
    end
    send_byte(acc[7:0]);
    send_byte(acc[15:8]);
    send_byte(8'hAA);
    p = {8'h11};
    send_frame(p, 16'h0000);
  endtask

  task automatic test_output_backpressure();
    logic [7:0] p[$];
    wait_for_drain();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_off_req  = 1'b1;
    random_payload(p, MaxLen);
    send_frame(p, 16'h0000);
    random_payload(p, 5);
    send_frame(p, 16'h0000);
    while (hold_off_req) @(posedge clk);
  endtask

  task automatic test_random_traffic(input logic [7:0] start, input int src_pct,
                                     input int sink_pct);
    logic [7:0] p[$];
    int         goal;
    int         pick;
    int         n;
    write_start_byte(start);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    goal = bytes_sent + RxBurstTarget;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      n    = ($urandom_range(99) < 5) ? MaxLen :
             ($urandom_range(9) == 0) ? int'($urandom_range(9, MaxLen - 1)) :
             int'($urandom_range(0, 8));
      if (pick < 70) begin
        random_payload(p, n);
        send_frame(p, 16'h0000);
      end else if (pick < 80) begin
        random_payload(p, n);
        send_frame(p, 16'h1 << $urandom_range(15));
      end else if (pick < 88) begin
        send_byte(exp_start);
        send_byte(8'($urandom_range(MaxLen + 1, 255)));
      end else if (pick < 94) begin
        // drop the frame partway through
        n = $urandom_range(2, 8);
        send_byte(exp_start);
        send_byte(8'(n));
        repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_frames();
    test_oversized_length();
    test_midframe_start_change();
    test_output_backpressure();
    test_random_traffic(8'h00, 30, 30);
    test_random_traffic(8'hFF, 0, 0);
    test_random_traffic(8'($urandom), 60, 20);
    test_random_traffic(8'($urandom_range(0, MaxLen)), 20, 60);

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes under %0d start byte settings; %0d oversized lengths dropped.",
             bytes_sent, start_writes + 1, len_drops);
    $display("Checked %0d payload results and %0d end reports (%0d with good CRC).",
             payload_seen, reports_seen, crc_good_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cfp_pkg.sv
hdl/cfp_parser.sv
hdl/cfp_out_reg.sv
hdl/crc16_framed_byte_parser.sv
tb/crc16_framed_byte_parser_tb.sv
